// ===== hw/rtl/hyperwarp_starfield_engine_core_defines.svh =====
// Assertion macros shared by the starfield engine RTL.
// No dependencies; included by the files that carry assertions.
`ifndef HYPERWARP_STARFIELD_ENGINE_CORE_DEFINES_SVH
`define HYPERWARP_STARFIELD_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define HSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define HSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hse_pkg.sv =====
// Shared types, constants and the number generator step for the starfield engine.
// No dependencies.
`default_nettype none

package hse_pkg;

   localparam int unsigned NUM_STARS_DEF = 16;

   localparam logic [7:0] GEN_A_SEED       = 8'h3B;
   localparam logic [7:0] GEN_B_SEED       = 8'h67;
   localparam logic [7:0] SHIP_COL_HOME    = 8'h80;
   localparam logic [6:0] SHIP_ROW_HOME    = 7'h40;
   localparam logic [7:0] PHASE_COUNT_WARP = 8'h80;
   localparam logic [7:0] PHASE_COUNT_HOLD = 8'h40;
   localparam logic [7:0] SPIN_FLOOR       = 8'd2;

   typedef enum logic [2:0] {
      CMD_STEP = 3'd0,
      CMD_INIT = 3'd1,
      CMD_WARP = 3'd2,
      CMD_SPIN = 3'd3,
      CMD_SHIP = 3'd4
   } hse_cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_TRAILS = 3'd1,
      PH_ACCEL  = 3'd2,
      PH_RUSH   = 3'd3,
      PH_SPIN   = 3'd4,
      PH_HOLD   = 3'd5
   } hse_phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_CALC,
      ST_DRAW,
      ST_PHASE
   } hse_state_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] new_ship_x;
      logic [6:0] new_ship_y;
   } hse_req_type;

   typedef struct packed {
      logic [7:0] pixel_x;
      logic [6:0] pixel_y;
      logic       lit;
      logic       warp_done;
      logic       last;
   } hse_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;        // request transaction taken this cycle
      logic fill_star;     // load one table entry from the generator
      logic fill_last;     // final fill entry: reseed afterwards
      logic calc_star;     // move current star, emit erase when speed is nonzero
      logic emit_draw;     // emit draw of the moved star
      logic star_last;     // current star is the final one
      logic phase_update;  // advance warp / spin-down sequencer
   } hse_dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;      // output register can take a transaction
      logic speed_nz;      // erases are emitted
   } hse_dp_status_type;

   // One add-with-carry generator step.
   function automatic logic [7:0] gen_next(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + 9'd9;
      return s[7:0] + b + {7'd0, s[8]};
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hse_ctrl.sv =====
// Sequencing state machine of the starfield engine.
// Depends on hse_pkg and the shared assertion macros.
`default_nettype none
`include "hyperwarp_starfield_engine_core_defines.svh"

module hse_ctrl
   import hse_pkg::*;
#(
   parameter int unsigned NUM_STARS = NUM_STARS_DEF,
   localparam int unsigned IDX_W = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_cmd,
   input  wire hse_dp_status_type status,
   output hse_dp_cmd_type         dp_cmd,
   output logic [IDX_W-1:0]       star_idx
);

   hse_state_type    state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             idx_last;
   logic             accept;

   assign idx_last = (idx_ff == IDX_W'(NUM_STARS - 1));
   assign star_idx = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      dp_cmd    = '0;
      req_stall = 1'b1;
      accept    = 1'b0;
      dp_cmd.star_last = idx_last;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
            dp_cmd.accept = accept;
            idx_in    = '0;
            if (accept && req_cmd == CMD_STEP) begin
               state_in = ST_CALC;
            end else if (accept && req_cmd == CMD_INIT) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            dp_cmd.fill_star = 1'b1;
            dp_cmd.fill_last = idx_last;
            if (idx_last) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_CALC: begin
            if (!status.speed_nz || status.out_free) begin
               dp_cmd.calc_star = 1'b1;
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (status.out_free) begin
               dp_cmd.emit_draw = 1'b1;
               if (idx_last) begin
                  state_in = ST_PHASE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_CALC;
               end
            end
         end
         ST_PHASE: begin
            dp_cmd.phase_update = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `HSE_ASSERT_NEXT(a_phase_then_idle, clock, reset, state_ff == ST_PHASE,
      state_ff == ST_IDLE, "phase update not followed by idle")
   `HSE_ASSERT_NOW(a_one_dp_action, clock, reset, 1'b1,
      $onehot0({dp_cmd.accept, dp_cmd.fill_star, dp_cmd.calc_star, dp_cmd.emit_draw,
                dp_cmd.phase_update}), "more than one datapath action in a cycle")
   `HSE_ASSERT_NOW(a_stall_when_busy, clock, reset, state_ff != ST_IDLE,
      req_stall, "request side open while busy")

endmodule

`default_nettype wire

// ===== hw/rtl/hse_dp.sv =====
// Datapath of the starfield engine: star table, generator, ship, phase
// sequencer registers and the output register. Depends on hse_pkg and the macros.
`default_nettype none
`include "hyperwarp_starfield_engine_core_defines.svh"

module hse_dp
   import hse_pkg::*;
#(
   parameter int unsigned NUM_STARS = NUM_STARS_DEF,
   localparam int unsigned IDX_W = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hse_req_type       req_data,
   input  wire hse_dp_cmd_type    dp_cmd,
   input  wire logic [IDX_W-1:0]  star_idx,
   output hse_dp_status_type      status,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output hse_rsp_type            rsp_data
);

   logic [7:0]    star_col_ff [NUM_STARS];
   logic [7:0]    star_col_in [NUM_STARS];
   logic [6:0]    star_row_ff [NUM_STARS];
   logic [6:0]    star_row_in [NUM_STARS];
   logic [7:0]    gen_a_ff, gen_a_in, gen_b_ff, gen_b_in;
   logic [7:0]    ship_col_ff, ship_col_in;
   logic [6:0]    ship_row_ff, ship_row_in;
   logic [7:0]    speed_ff, speed_in;
   logic [7:0]    count_ff, count_in;
   hse_phase_type phase_ff, phase_in;
   logic [7:0]    draw_x_ff, draw_x_in;
   logic [6:0]    draw_y_ff, draw_y_in;
   logic          rsp_valid_ff, rsp_valid_in;
   hse_rsp_type   rsp_data_ff, rsp_data_in;

   logic [7:0] sx, gen1, gen2, dx, x_down, x_new, dy, ty_up, ty_dn, ty, nx;
   logic [6:0] sy, ny;
   logic [8:0] tx_up;
   logic [4:0] st_x, st_y;
   logic       x_ahead, x_respawn, y_ahead, respawn;
   logic [7:0] speed_plus2, count_dec, speed_dec;
   logic       done_now, load_out, out_free;

   assign sx   = star_col_ff[star_idx];
   assign sy   = star_row_ff[star_idx];
   assign gen1 = gen_next(gen_a_ff, gen_b_ff);
   assign gen2 = gen_next(gen1, gen_a_ff);

   // Column: push away from the ship by 1 + distance/16.
   assign dx        = sx - ship_col_ff;
   assign x_ahead   = (sx >= ship_col_ff);
   assign tx_up     = {1'b0, sx} + {5'd0, dx[7:4]} + 9'd1;
   assign st_x      = {1'b0, ~dx[7:4]} + 5'd1;
   assign x_down    = sx - {3'd0, st_x};
   assign x_respawn = x_ahead ? tx_up[8] : (sx < {3'd0, st_x});
   assign x_new     = x_ahead ? tx_up[7:0] : x_down;

   // Row: same rule; bit 7 of the 8-bit result flags leaving the field.
   assign dy      = {1'b0, sy} - {1'b0, ship_row_ff};
   assign y_ahead = (sy >= ship_row_ff);
   assign ty_up   = {1'b0, sy} + {4'd0, dy[7:4]} + 8'd1;
   assign st_y    = {1'b0, ~dy[7:4]} + 5'd1;
   assign ty_dn   = {1'b0, sy} - {3'd0, st_y};
   assign ty      = y_ahead ? ty_up : ty_dn;

   assign respawn = x_respawn || ty[7];
   assign nx      = respawn ? gen1 : x_new;
   assign ny      = respawn ? gen2[6:0] : ty[6:0];

   assign speed_plus2 = speed_ff + 8'd2;
   assign speed_dec   = speed_ff - 8'd1;
   assign count_dec   = count_ff - 8'd1;
   assign done_now    = (phase_ff == PH_RUSH) && speed_plus2[7];

   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign status.out_free = out_free;
   assign status.speed_nz = (speed_ff != 8'd0);
   assign load_out        = dp_cmd.emit_draw || (dp_cmd.calc_star && status.speed_nz);

   always_comb begin
      star_col_in  = star_col_ff;
      star_row_in  = star_row_ff;
      gen_a_in     = gen_a_ff;
      gen_b_in     = gen_b_ff;
      ship_col_in  = ship_col_ff;
      ship_row_in  = ship_row_ff;
      speed_in     = speed_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      draw_x_in    = draw_x_ff;
      draw_y_in    = draw_y_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (dp_cmd.accept) begin
         case (req_data.cmd)
            CMD_INIT: begin
               gen_a_in    = GEN_A_SEED;
               gen_b_in    = GEN_B_SEED;
               ship_col_in = SHIP_COL_HOME;
               ship_row_in = SHIP_ROW_HOME;
               speed_in    = 8'd0;
               count_in    = PHASE_COUNT_WARP;
               phase_in    = PH_TRAILS;
            end
            CMD_WARP: begin
               gen_a_in = GEN_A_SEED;
               gen_b_in = GEN_B_SEED;
               speed_in = 8'd0;
               count_in = PHASE_COUNT_WARP;
               phase_in = PH_TRAILS;
            end
            CMD_SPIN: begin
               gen_a_in = GEN_A_SEED;
               gen_b_in = GEN_B_SEED;
               phase_in = PH_SPIN;
            end
            CMD_SHIP: begin
               ship_col_in = req_data.new_ship_x;
               ship_row_in = req_data.new_ship_y;
            end
            default: begin
            end
         endcase
      end

      if (dp_cmd.fill_star) begin
         star_col_in[star_idx] = gen1;
         star_row_in[star_idx] = gen2[6:0];
         // the warp start that ends an init reseeds the generator
         gen_a_in = dp_cmd.fill_last ? GEN_A_SEED : gen2;
         gen_b_in = dp_cmd.fill_last ? GEN_B_SEED : gen1;
      end

      if (dp_cmd.calc_star) begin
         star_col_in[star_idx] = nx;
         star_row_in[star_idx] = ny;
         draw_x_in = nx;
         draw_y_in = ny;
         if (respawn) begin
            gen_a_in = gen2;
            gen_b_in = gen1;
         end
         // only touch the output register when an erase goes out; a draw may be waiting
         if (status.speed_nz) begin
            rsp_data_in = '{pixel_x: sx, pixel_y: sy, lit: 1'b0, warp_done: 1'b0,
                            last: 1'b0};
         end
      end

      if (dp_cmd.emit_draw) begin
         rsp_data_in = '{pixel_x: draw_x_ff, pixel_y: draw_y_ff, lit: 1'b1,
                         warp_done: dp_cmd.star_last && done_now,
                         last: dp_cmd.star_last};
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end

      if (dp_cmd.phase_update) begin
         case (phase_ff)
            PH_TRAILS: begin
               count_in = count_dec;
               if (count_dec == 8'd0) begin
                  count_in = PHASE_COUNT_WARP;
                  speed_in = 8'd1;
                  gen_a_in = GEN_A_SEED;
                  gen_b_in = GEN_B_SEED;
                  phase_in = PH_ACCEL;
               end
            end
            PH_ACCEL: begin
               count_in = count_dec;
               if (count_dec == 8'd0) begin
                  speed_in = speed_ff + 8'd1;
                  phase_in = PH_RUSH;
               end
            end
            PH_RUSH: begin
               speed_in = speed_plus2;
               if (speed_plus2[7]) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_SPIN: begin
               speed_in = speed_dec;
               if (speed_dec == SPIN_FLOOR) begin
                  count_in = PHASE_COUNT_HOLD;
                  gen_a_in = GEN_A_SEED;
                  gen_b_in = GEN_B_SEED;
                  phase_in = PH_HOLD;
               end
            end
            PH_HOLD: begin
               count_in = count_dec;
               if (count_dec == 8'd0) begin
                  speed_in = 8'd0;
                  count_in = PHASE_COUNT_WARP;
                  gen_a_in = GEN_A_SEED;
                  gen_b_in = GEN_B_SEED;
                  phase_in = PH_TRAILS;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         star_col_ff  <= '{default: '0};
         star_row_ff  <= '{default: '0};
         gen_a_ff     <= GEN_A_SEED;
         gen_b_ff     <= GEN_B_SEED;
         ship_col_ff  <= SHIP_COL_HOME;
         ship_row_ff  <= SHIP_ROW_HOME;
         speed_ff     <= 8'd0;
         count_ff     <= PHASE_COUNT_WARP;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         star_col_ff  <= star_col_in;
         star_row_ff  <= star_row_in;
         gen_a_ff     <= gen_a_in;
         gen_b_ff     <= gen_b_in;
         ship_col_ff  <= ship_col_in;
         ship_row_ff  <= ship_row_in;
         speed_ff     <= speed_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      draw_x_ff   <= draw_x_in;
      draw_y_ff   <= draw_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HSE_ASSERT_NOW(a_done_on_last, clock, reset, rsp_valid_ff && rsp_data_ff.warp_done,
      rsp_data_ff.last, "warp_done without last")
   `HSE_ASSERT_NOW(a_erase_needs_speed, clock, reset, rsp_valid_ff && !rsp_data_ff.lit,
      speed_ff != 8'd0, "erase pending while speed is zero")
   `HSE_ASSERT_NOW(a_no_overwrite, clock, reset, load_out,
      !(rsp_valid_ff && rsp_stall), "output register overwritten while stalled")

endmodule

`default_nettype wire

// ===== hw/rtl/hyperwarp_starfield_engine_core.sv =====
// After a step is accepted, the move state registers the first star's erase, or at
// speed zero the draw state registers its draw; each waits while the output register
// is held. A step runs a move and a draw state per star, then the phase update;
// an init fills one table entry per cycle; other commands finish at acceptance.
// Reset (synchronous, active high) clears the star table, reseeds the generator,
// homes the ship and idles the phase sequencer; no clearing pass is needed.
`default_nettype none

// Starfield engine top level: controller (hse_ctrl) plus datapath (hse_dp).
// Depends on hse_pkg.
//
// Request transactions carry a command. Step moves every star outward from the
// ship, respawning from the generator those that leave the 256 x 128 field,
// and produces an erase (at nonzero speed) and a draw transaction per star. The
// final draw carries last, and warp_done when the step ends the rush phase.
// Non-step commands produce no response transactions.
//
// req_stall is low only while the controller is idle; a response waiting in the
// output register does not block acceptance of the next request.
module hyperwarp_starfield_engine_core
   import hse_pkg::*;
#(
   parameter int unsigned NUM_STARS = NUM_STARS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire hse_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output hse_rsp_type      rsp_data
);

   localparam int unsigned IDX_W = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;

   hse_dp_cmd_type    dp_cmd;
   hse_dp_status_type dp_status;
   logic [IDX_W-1:0]  star_idx;

   // Sequencer: walks stars, waits on the output register, runs the phase step.
   hse_ctrl #(
      .NUM_STARS (NUM_STARS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_data.cmd),
      .status    (dp_status),
      .dp_cmd    (dp_cmd),
      .star_idx  (star_idx)
   );

   // Star table, generator, ship/phase registers and response register.
   hse_dp #(
      .NUM_STARS (NUM_STARS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .dp_cmd    (dp_cmd),
      .star_idx  (star_idx),
      .status    (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sim/hse_starfield_checker.sv =====
// Scoreboard for the starfield engine: predicts the pixel transactions of each command and
// compares them with what the block produces. Depends on hse_pkg.
module hse_starfield_checker
   import hse_pkg::*;
#(
   parameter int unsigned NUM_STARS = NUM_STARS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire hse_req_type req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire hse_rsp_type rsp_data,
   output int unsigned      pending_results,
   output int unsigned      fault_count,
   output int unsigned      pixels_checked,
   output int unsigned      warps_completed
);

   // shadow copy of the engine state
   logic [7:0]    col_tab [NUM_STARS];
   logic [6:0]    row_tab [NUM_STARS];
   logic [7:0]    mix_a, mix_b;
   logic [7:0]    ship_x;
   logic [6:0]    ship_y;
   logic [7:0]    speed;
   logic [7:0]    phase_ticks;
   hse_phase_type warp_phase;

   hse_rsp_type   expected_pixels [$];

   task automatic reseed();
      mix_a = GEN_A_SEED;
      mix_b = GEN_B_SEED;
   endtask

   // add-with-carry generator, one step
   function automatic logic [7:0] roll();
      logic [8:0] sum;
      logic [7:0] nxt;
      sum   = {1'b0, mix_a} + 9'd9;
      nxt   = sum[7:0] + mix_b + {7'd0, sum[8]};
      mix_b = mix_a;
      mix_a = nxt;
      return nxt;
   endfunction

   task automatic begin_warp();
      speed       = 8'd0;
      phase_ticks = PHASE_COUNT_WARP;
      reseed();
      warp_phase  = PH_TRAILS;
   endtask

   function automatic hse_rsp_type make_pixel(input logic [7:0] x, input logic [6:0] y,
                                              input logic on);
      hse_rsp_type px;
      px           = '0;
      px.pixel_x   = x;
      px.pixel_y   = y;
      px.lit       = on;
      return px;
   endfunction

   task automatic advance_starfield(input hse_req_type txn);
      hse_rsp_type batch [2*NUM_STARS];
      int unsigned n;
      int          i;
      logic [7:0]  sx, nx, dx, dy, inv, span, ty, rnd;
      logic [6:0]  sy, ny;
      logic [8:0]  tx;
      logic        gone, finished;
      n        = 0;
      finished = 1'b0;
      case (txn.cmd)
         CMD_INIT: begin
            reseed();
            for (i = 0; i < NUM_STARS; i++) begin
               col_tab[i] = roll();
               rnd        = roll();
               row_tab[i] = rnd[6:0];
            end
            ship_x = SHIP_COL_HOME;
            ship_y = SHIP_ROW_HOME;
            begin_warp();
         end
         CMD_WARP: begin_warp();
         CMD_SPIN: begin
            reseed();
            warp_phase = PH_SPIN;
         end
         CMD_SHIP: begin
            ship_x = txn.new_ship_x;
            ship_y = txn.new_ship_y;
         end
         CMD_STEP: begin
            for (i = 0; i < NUM_STARS; i++) begin
               sx   = col_tab[i];
               sy   = row_tab[i];
               gone = 1'b0;
               ny   = '0;
               dx   = sx - ship_x;
               if (sx >= ship_x) begin
                  tx   = {1'b0, sx} + {5'd0, dx[7:4]} + 9'd1;
                  gone = tx[8];
                  nx   = tx[7:0];
               end else begin
                  inv  = ~dx;
                  span = {4'd0, inv[7:4]} + 8'd1;
                  gone = sx < span;
                  nx   = sx - span;
               end
               // the row only moves while the column stays inside the field
               if (!gone) begin
                  dy = {1'b0, sy} - {1'b0, ship_y};
                  if (sy >= ship_y) begin
                     ty = {1'b0, sy} + {4'd0, dy[7:4]} + 8'd1;
                  end else begin
                     inv = ~dy;
                     ty  = {1'b0, sy} - ({4'd0, inv[7:4]} + 8'd1);
                  end
                  gone = ty[7];
                  ny   = ty[6:0];
               end
               if (gone) begin
                  nx  = roll();
                  rnd = roll();
                  ny  = rnd[6:0];
               end
               if (speed != 8'd0) begin
                  batch[n] = make_pixel(sx, sy, 1'b0);
                  n++;
               end
               col_tab[i] = nx;
               row_tab[i] = ny;
               batch[n]   = make_pixel(nx, ny, 1'b1);
               n++;
            end
            case (warp_phase)
               PH_TRAILS: begin
                  phase_ticks = phase_ticks - 8'd1;
                  if (phase_ticks == 8'd0) begin
                     phase_ticks = PHASE_COUNT_WARP;
                     speed       = 8'd1;
                     reseed();
                     warp_phase  = PH_ACCEL;
                  end
               end
               PH_ACCEL: begin
                  phase_ticks = phase_ticks - 8'd1;
                  if (phase_ticks == 8'd0) begin
                     speed      = speed + 8'd1;
                     warp_phase = PH_RUSH;
                  end
               end
               PH_RUSH: begin
                  speed = speed + 8'd2;
                  if (speed[7]) begin
                     warp_phase = PH_IDLE;
                     finished   = 1'b1;
                     warps_completed++;
                  end
               end
               PH_SPIN: begin
                  speed = speed - 8'd1;
                  if (speed == SPIN_FLOOR) begin
                     phase_ticks = PHASE_COUNT_HOLD;
                     reseed();
                     warp_phase  = PH_HOLD;
                  end
               end
               PH_HOLD: begin
                  phase_ticks = phase_ticks - 8'd1;
                  if (phase_ticks == 8'd0)
                     begin_warp();
               end
               default: ;
            endcase
            batch[n-1].last      = 1'b1;
            batch[n-1].warp_done = finished;
            for (i = 0; i < n; i++)
               expected_pixels.push_back(batch[i]);
         end
         default: ;  // spare command codes change nothing
      endcase
   endtask

   task automatic check_pixel(input hse_rsp_type got);
      hse_rsp_type want;
      if (expected_pixels.size() == 0) begin
         $error("unexpected pixel transaction: x=%0d y=%0d lit=%0b",
                got.pixel_x, got.pixel_y, got.lit);
         fault_count++;
      end else begin
         want = expected_pixels.pop_front();
         pixels_checked++;
         if (got.pixel_x !== want.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
            fault_count++;
         end
         if (got.pixel_y !== want.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
            fault_count++;
         end
         if (got.lit !== want.lit) begin
            $error("lit: expected %0b, got %0b", want.lit, got.lit);
            fault_count++;
         end
         if (got.warp_done !== want.warp_done) begin
            $error("warp_done: expected %0b, got %0b", want.warp_done, got.warp_done);
            fault_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            fault_count++;
         end
      end
   endtask

   // results are checked before the request of the same edge is predicted;
   // a request never produces a result at its own acceptance edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STARS; i++) begin
            col_tab[i] = '0;
            row_tab[i] = '0;
         end
         reseed();
         ship_x      = SHIP_COL_HOME;
         ship_y      = SHIP_ROW_HOME;
         speed       = 8'd0;
         phase_ticks = PHASE_COUNT_WARP;
         warp_phase  = PH_IDLE;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_pixel(rsp_data);
         if (req_valid && !req_stall)
            advance_starfield(req_data);
      end
      pending_results <= expected_pixels.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// Top of the starfield engine testbench: clock, reset, command stimulus, pixel-side
// back-pressure, watchdog and verdict. Depends on hse_pkg, the engine RTL and the checker.
module tb_top
   import hse_pkg::*;
();

   localparam int unsigned FIELD_STARS    = NUM_STARS_DEF;
   localparam int unsigned QUIET_LIMIT    = 5000;  // idle cycles before giving up
   localparam int unsigned HOLD_CYCLES    = 300;   // long pixel-side hold-off
   localparam int unsigned HOLD_AT_STEP   = 30;
   localparam int unsigned TAIL_CYCLES    = 2 * FIELD_STARS + 8;
   localparam int unsigned WARP_RUN_STEPS = 322;   // trails 128 + accelerate 128 + rush 63, with 3 to spare
   localparam int unsigned MODE_SPAN      = 40;    // transactions per idling mode
   localparam logic [2:0]  SPARE_CMD_LO   = 3'd5;
   localparam logic [2:0]  SPARE_CMD_HI   = 3'd7;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   hse_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   hse_rsp_type rsp_data;

   int unsigned pending_results, fault_count, pixels_checked, warps_completed;

   // stimulus knobs, written by the command process only
   int unsigned idle_pct        = 0;
   int unsigned stall_pct       = 0;
   int unsigned holds_requested = 0;
   int unsigned items_sent      = 0;

   // owned by the pixel-side process
   int unsigned holds_served = 0;

   int unsigned quiet_cycles = 0;

   hyperwarp_starfield_engine_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   hse_starfield_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .pending_results (pending_results),
      .fault_count     (fault_count),
      .pixels_checked  (pixels_checked),
      .warps_completed (warps_completed)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Pixel side: random stall at the current rate, or a long hold-off when the
   // command process asks for one. The hold is counted here, cycle by cycle.
   initial begin
      forever begin
         @(posedge clock);
         if (holds_served != holds_requested) begin
            holds_served = holds_served + 1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Watchdog: any stretch with no transaction on either channel longer than
   // QUIET_LIMIT means the block has hung (or lost results).
   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending_results);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Rotate the idling mode every MODE_SPAN transactions:
   // none, sender gaps, pixel-side stalls, both lightly.
   task automatic pick_idling();
      case ((items_sent / MODE_SPAN) % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 69; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 69; end
         default: begin idle_pct = 9; stall_pct = 9; end
      endcase
   endtask

   // One command transaction. Valid stays high from one transaction to the next
   // unless a gap is taken; the gap lowers it on a different edge than the raise.
   task automatic send_command(input logic [2:0] code, input logic [7:0] col,
                               input logic [6:0] row);
      hse_req_type txn;
      txn.cmd        = code;
      txn.new_ship_x = col;
      txn.new_ship_y = row;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= txn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // spare codes are ignored by the block and do not count
      if (code <= CMD_SHIP) begin
         items_sent++;
         pick_idling();
      end
   endtask

   task automatic send_step();
      logic [7:0] col;
      logic [6:0] row;
      col = 8'($urandom_range(255));
      row = 7'($urandom_range(127));
      send_command(CMD_STEP, col, row);
   endtask

   // Mixed traffic: mostly steps, with restarts, spin-downs, ship moves and
   // spare codes breaking up whatever sequence is under way.
   task automatic send_random_command();
      int unsigned pick;
      logic [2:0]  code;
      logic [7:0]  col;
      logic [6:0]  row;
      pick = $urandom_range(99);
      col  = 8'($urandom_range(255));
      row  = 7'($urandom_range(127));
      if (pick < 55)
         code = CMD_STEP;
      else if (pick < 63)
         code = CMD_INIT;
      else if (pick < 71)
         code = CMD_WARP;
      else if (pick < 79)
         code = CMD_SPIN;
      else if (pick < 94)
         code = CMD_SHIP;
      else
         code = 3'($urandom_range(SPARE_CMD_HI, SPARE_CMD_LO));
      send_command(code, col, row);
   endtask

   // Stop offering commands until the checker has seen every predicted pixel.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned steps;
      int unsigned pick;
      int          c;
      logic [7:0]  col;
      logic [6:0]  row;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // step straight out of reset: all stars at the corner, speed zero so no erases
      send_step();
      // ship at the far corner, then at the origin
      send_command(CMD_SHIP, 8'hFF, 7'h7F);
      send_step();
      send_command(CMD_SHIP, 8'h00, 7'h00);
      send_step();
      // spare codes with busy payloads: no effect, no pixels
      for (c = SPARE_CMD_LO; c <= SPARE_CMD_HI; c++)
         send_command(c[2:0], (c[0] ? 8'hAA : 8'h55), (c[0] ? 7'h55 : 7'h2A));
      // init fills the table, homes the ship (payload ignored) and starts trails
      send_command(CMD_INIT, 8'hFF, 7'h7F);
      send_step();
      send_step();
      // spin-down from speed zero wraps the speed to 255: erases appear
      send_command(CMD_SPIN, 8'h00, 7'h00);
      send_step();
      send_step();
      send_step();
      // restart the warp: speed back to zero
      send_command(CMD_WARP, 8'h00, 7'h00);
      send_step();
      send_command(CMD_SHIP, SHIP_COL_HOME, SHIP_ROW_HOME);
      send_step();
      // spin-down immediately overridden by a warp start
      send_command(CMD_SPIN, 8'hFF, 7'h7F);
      send_command(CMD_WARP, 8'hFF, 7'h7F);
      send_step();
      wait_for_drain();

      // ---- random part ----
      repeat (12) send_random_command();

      // Full warp from a fresh field: trails, accelerate, rush until warp_done,
      // with ship moves and spare codes mixed in (they leave the sequencer alone).
      // Early on the pixel side holds off for a long stretch while steps keep coming.
      col = 8'($urandom_range(255));
      row = 7'($urandom_range(127));
      send_command(CMD_INIT, col, row);
      steps = 0;
      while (steps < WARP_RUN_STEPS) begin
         if (steps == HOLD_AT_STEP && holds_requested == 0)
            holds_requested++;
         pick = $urandom_range(99);
         col  = 8'($urandom_range(255));
         row  = 7'($urandom_range(127));
         if (pick < 4) begin
            send_command(CMD_SHIP, col, row);
         end else if (pick < 6) begin
            send_command(3'($urandom_range(SPARE_CMD_HI, SPARE_CMD_LO)), col, row);
         end else begin
            send_step();
            steps++;
         end
      end

      repeat (6) send_random_command();

      // ---- wind down ----
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d commands and %0d pixel transactions checked,",
               items_sent, pixels_checked);
      $display("including %0d warp sequences carried through to warp_done.",
               warps_completed);
      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/hse_pkg.sv
hw/rtl/hse_ctrl.sv
hw/rtl/hse_dp.sv
hw/rtl/hyperwarp_starfield_engine_core.sv
sim/hse_starfield_checker.sv
sim/tb_top.sv
